// ----- src/fcrl_pkg.sv -----
// Package for the field calibrated resistance-to-length converter.
// Holds opcodes, register indexes, fixed-point limits and the request/result
// structs shared by the serial divider, the serial multiplier and the top level.
package fcrl_pkg;

    localparam int MAX_LENGTH_M = 1000;
    localparam logic [31:0] MAX_Q = 32'(MAX_LENGTH_M * 65536);
    localparam logic signed [31:0] SLOPE_MIN = 32'sd16;
    localparam logic [31:0] INT32_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] INT32_MIN = 32'h8000_0000;

    localparam int DIV_STEPS = 56;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int MUL_STEPS = 31;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS);

    typedef enum logic [1:0] {
        OP_CLEAR     = 2'd0,
        OP_SET_ZERO  = 2'd1,
        OP_APPLY_REF = 2'd2,
        OP_MEASURE   = 2'd3
    } opcode_t;

    typedef enum logic {
        REG_BASE_SLOPE = 1'b0,
        REG_BASE_ZERO  = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    // divider: quotient of {num, 24'b0} / den
    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [30:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic        ovf;
        logic [31:0] quot;
    } div_res_t;

    typedef struct packed {
        logic        start;
        logic [30:0] a;
        logic [30:0] b;
    } mul_req_t;

    typedef struct packed {
        logic        done;
        logic [61:0] prod;
    } mul_res_t;

endpackage

// ----- src/fcrl_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle.
// Keeps the low 32 quotient bits plus a sticky overflow flag. Uses fcrl_pkg.
module fcrl_div
    import fcrl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_res_t res
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [55:0]          dvd_reg, dvd_next;
    logic [30:0]          rem_reg, rem_next;
    logic [30:0]          den_reg, den_next;
    logic [31:0]          quot_reg, quot_next;
    logic                 ovf_reg, ovf_next;
    logic [31:0]          trial;
    logic                 fits;

    assign trial = {rem_reg, dvd_reg[55]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        ovf_next  = ovf_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = {req.num, 24'b0};
            rem_next  = '0;
            den_next  = req.den;
            quot_next = '0;
            ovf_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            dvd_next  = {dvd_reg[54:0], 1'b0};
            rem_next  = fits ? 31'(trial - {1'b0, den_reg}) : trial[30:0];
            quot_next = {quot_reg[30:0], fits};
            ovf_next  = ovf_reg | quot_reg[31];
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
        ovf_reg  <= ovf_next;
    end

    assign res.done = done_reg;
    assign res.ovf  = ovf_reg;
    assign res.quot = quot_reg;

endmodule

// ----- src/fcrl_mul.sv -----
// Bit-serial shift-add multiplier, 31 by 31 bits unsigned, one bit per cycle.
// The multiplier shares its register with the low product bits. Uses fcrl_pkg.
module fcrl_mul
    import fcrl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_res_t res
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic [30:0]          a_reg, a_next;
    logic [30:0]          acc_reg, acc_next;
    logic [30:0]          lo_reg, lo_next;
    logic [31:0]          sum;

    assign sum = {1'b0, acc_reg} + (lo_reg[0] ? {1'b0, a_reg} : 32'd0);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        acc_next  = acc_reg;
        lo_next   = lo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            a_next    = req.a;
            acc_next  = '0;
            lo_next   = req.b;
        end
        else if (busy_reg)
        begin
            acc_next = sum[31:1];
            lo_next  = {sum[0], lo_reg[30:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == MUL_CNT_W'(MUL_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        acc_reg <= acc_next;
        lo_reg  <= lo_next;
    end

    assign res.done = done_reg;
    assign res.prod = {acc_reg, lo_reg};

endmodule

// ----- src/field_calibrated_resistance_length.sv -----
// Flow, input transfer to result valid: clear, set zero and anything settled at setup go
// from setup straight to done; measure and apply reference with pending zero run the
// 56-step serial divider; apply reference from base slope runs the 31-step serial multiplier.
// One item at a time: the next transfer is taken the cycle after the result is registered,
// and while the output stalls a finished item waits in done. Reset clears calibration state and
// config registers to zero. Depends on fcrl_pkg, fcrl_div, fcrl_mul.
module field_calibrated_resistance_length
    import fcrl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // opcode[1:0], resistance[33:2], ref_length[65:34]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // ok[0], length_out[26:1]
);

    state_t state_reg, state_next;

    logic [31:0] base_slope_reg, base_zero_reg;
    logic        field_valid_reg, pending_valid_reg;
    logic [31:0] field_slope_reg, field_zero_reg, pending_zero_reg;

    opcode_t     op_reg;
    logic [31:0] res_reg, len_reg;
    logic        fail_reg, fail_next;
    logic        short_reg, short_next;

    logic        out_valid_reg;
    logic        out_ok_reg;
    logic [25:0] out_len_reg;

    logic        in_xfer, out_free;
    logic        go_div, go_mul, set_fail, set_short;
    logic        commit;
    div_req_t    div_req;
    div_res_t    div_res;
    mul_req_t    mul_req;
    mul_res_t    mul_res;

    logic [31:0] sel_slope, sel_zero;
    logic [32:0] d_meas, d_app;
    logic        len_pos;

    logic        r_ok;
    logic [25:0] r_len;
    logic        r_upd;
    logic [31:0] r_slope, r_zero;
    logic        q_sat;
    logic [39:0] z_diff;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;

    // operand selection and setup decisions
    always_comb
    begin
        sel_slope = field_valid_reg ? field_slope_reg : base_slope_reg;
        sel_zero  = field_valid_reg ? field_zero_reg : base_zero_reg;
        d_meas    = {res_reg[31], res_reg} - {sel_zero[31], sel_zero};
        d_app     = {res_reg[31], res_reg} - {pending_zero_reg[31], pending_zero_reg};
        len_pos   = !len_reg[31] && (len_reg != '0);
        go_div    = 1'b0;
        go_mul    = 1'b0;
        set_fail  = 1'b0;
        set_short = 1'b0;
        unique case (op_reg)
            OP_MEASURE:
            begin
                if ($signed(sel_slope) <= SLOPE_MIN)
                    set_fail = 1'b1;
                else if (d_meas[32] || d_meas == '0)
                    set_short = 1'b1;
                else
                    go_div = 1'b1;
            end
            OP_APPLY_REF:
            begin
                if (!len_pos)
                    set_fail = 1'b1;
                else if (pending_valid_reg)
                begin
                    if (d_app[32] || d_app == '0)
                        set_fail = 1'b1;
                    else
                        go_div = 1'b1;
                end
                else if ($signed(base_slope_reg) <= SLOPE_MIN)
                    set_fail = 1'b1;
                else
                    go_mul = 1'b1;
            end
            OP_CLEAR, OP_SET_ZERO:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_xfer) state_next = ST_SETUP;
            ST_SETUP:
            begin
                if (go_div)
                    state_next = ST_DIV;
                else if (go_mul)
                    state_next = ST_MUL;
                else
                    state_next = ST_DONE;
            end
            ST_MUL:   if (mul_res.done) state_next = ST_DONE;
            ST_DIV:   if (div_res.done) state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // state machine outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        div_req.start = 1'b0;
        div_req.num   = (op_reg == OP_MEASURE) ? d_meas[31:0] : d_app[31:0];
        div_req.den   = (op_reg == OP_MEASURE) ? sel_slope[30:0] : len_reg[30:0];
        mul_req.start = 1'b0;
        mul_req.a     = base_slope_reg[30:0];
        mul_req.b     = len_reg[30:0];
        commit        = 1'b0;
        fail_next     = fail_reg;
        short_next    = short_reg;
        unique case (state_reg)
            ST_IDLE:  s_axis_tready = 1'b1;
            ST_SETUP:
            begin
                div_req.start = go_div;
                mul_req.start = go_mul;
                fail_next     = set_fail;
                short_next    = set_short;
            end
            ST_MUL, ST_DIV:
            begin
            end
            ST_DONE:  commit = out_free;
            default:
            begin
            end
        endcase
    end

    fcrl_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .res   (div_res)
    );

    fcrl_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .res   (mul_res)
    );

    // final result and calibration update
    always_comb
    begin
        q_sat   = div_res.ovf || div_res.quot[31];
        z_diff  = {{8{res_reg[31]}}, res_reg} - {2'b0, mul_res.prod[61:24]};
        r_ok    = 1'b1;
        r_len   = '0;
        r_upd   = 1'b0;
        r_slope = base_slope_reg;
        r_zero  = pending_zero_reg;
        unique case (op_reg)
            OP_MEASURE:
            begin
                if (fail_reg)
                    r_ok = 1'b0;
                else if (!short_reg)
                begin
                    if (div_res.ovf || div_res.quot > MAX_Q)
                        r_len = MAX_Q[25:0];
                    else
                        r_len = div_res.quot[25:0];
                end
            end
            OP_APPLY_REF:
            begin
                if (fail_reg)
                    r_ok = 1'b0;
                else if (pending_valid_reg)
                begin
                    r_slope = q_sat ? INT32_MAX : div_res.quot;
                    r_zero  = pending_zero_reg;
                    if (!q_sat && div_res.quot <= 32'(SLOPE_MIN))
                        r_ok = 1'b0;
                    else
                        r_upd = 1'b1;
                end
                else
                begin
                    r_slope = base_slope_reg;
                    r_zero  = (z_diff[39] && !(&z_diff[38:31])) ? INT32_MIN : z_diff[31:0];
                    r_upd   = 1'b1;
                end
            end
            OP_CLEAR, OP_SET_ZERO:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            base_slope_reg    <= '0;
            base_zero_reg     <= '0;
            field_valid_reg   <= 1'b0;
            field_slope_reg   <= '0;
            field_zero_reg    <= '0;
            pending_valid_reg <= 1'b0;
            pending_zero_reg  <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index_t'(cfg_addr))
                    REG_BASE_SLOPE: base_slope_reg <= cfg_wr_data;
                    REG_BASE_ZERO:  base_zero_reg  <= cfg_wr_data;
                    default:
                    begin
                    end
                endcase
            end
            if (commit)
            begin
                if (op_reg == OP_CLEAR)
                begin
                    field_valid_reg   <= 1'b0;
                    field_slope_reg   <= '0;
                    field_zero_reg    <= '0;
                    pending_valid_reg <= 1'b0;
                    pending_zero_reg  <= '0;
                end
                else if (op_reg == OP_SET_ZERO)
                begin
                    pending_valid_reg <= 1'b1;
                    pending_zero_reg  <= res_reg;
                end
                else if (r_upd)
                begin
                    field_valid_reg   <= 1'b1;
                    field_slope_reg   <= r_slope;
                    field_zero_reg    <= r_zero;
                    pending_valid_reg <= 1'b0;
                    pending_zero_reg  <= '0;
                end
            end
            if (commit)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg  <= opcode_t'(s_axis_tdata[1:0]);
            res_reg <= s_axis_tdata[33:2];
            len_reg <= s_axis_tdata[65:34];
        end
        fail_reg  <= fail_next;
        short_reg <= short_next;
        if (commit)
        begin
            out_ok_reg  <= r_ok;
            out_len_reg <= r_len;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_len_reg, out_ok_reg};

endmodule

// ----- src/fcrl_checker.sv -----
// Port-level checks for field_calibrated_resistance_length, attached by bind.
// Depends on fcrl_pkg for the length limit.
module fcrl_checker
    import fcrl_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // a stalled result stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

    // a failed operation reports no length
    a_fail_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[26:1] == '0)
        else $error("nonzero length with failure");

    a_len_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[26:1] <= MAX_Q[25:0])
        else $error("length above limit");

    // one item in flight: busy right after a transfer in
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second transfer taken while busy");

endmodule

bind field_calibrated_resistance_length fcrl_checker u_fcrl_checker (.*);
